>>> hw/rtl/bdq_pkg.sv
// bdq_pkg: shared types and constants for the byte deque
`default_nettype none

package bdq_pkg;

  // default number of element slots
  localparam int unsigned DEPTH_DEFAULT = 1024;

  // fixed field widths
  localparam int unsigned DATA_W = 8;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned OCC_W  = 11;

  // operation codes
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4
  } opcode_t;

  // command transfer
  typedef struct packed {
    opcode_t           opcode;
    logic [DATA_W-1:0] push_data;
    logic [POS_W-1:0]  position;
  } cmd_t;

  // result transfer
  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              ok;
    logic [OCC_W-1:0]  occupancy;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/bdq_ram.sv
// bdq_ram: generic single-port ram with registered read
`default_nettype none

module bdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/byte_deque_top.sv
// byte_deque_top: byte deque on a circular ram with head pointer and count
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------
//   command  | in        | start & !busy      | cmd    (opcode, push_data, position)
//   result   | out       | strobe, one cycle  | result (data_out, ok, occupancy)
//
// One command per cycle; each result appears on the cycle after its command is
// taken, set by the registered read of the element ram. busy stays
// low: head, count and the ram write are all updated at the accepting edge, so
// the next command already sees them. Reset clears head, count and res_valid;
// the ram holds garbage until pushed. The receiver cannot stall the result.
`default_nettype none

module byte_deque_top #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire bdq_pkg::cmd_t cmd,
  output logic               strobe,
  output bdq_pkg::res_t      result
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SW    =
    ((CNT_W > bdq_pkg::POS_W) ? CNT_W : bdq_pkg::POS_W) + 1;

  // (a + b) mod DEPTH for a < DEPTH and b <= DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [SW-1:0] a,
                                                 input logic [SW-1:0] b);
    logic [SW-1:0] s;
    s = a + b;
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                       accept;
  logic                       full;
  logic                       empty;
  logic [SW-1:0]              head_ext;
  logic [SW-1:0]              count_ext;
  logic [SW-1:0]              pos_ext;
  logic [PTR_W-1:0]           ram_addr;
  logic                       ram_we;
  logic [bdq_pkg::DATA_W-1:0] ram_rdata;
  logic                       op_ok;
  logic                       op_rd;

  // result register
  logic                       res_valid;
  logic                       res_ok;
  logic                       res_rd;
  logic [bdq_pkg::OCC_W-1:0]  res_occ;
  logic [SW-1:0]              occ_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign head_ext  = SW'(head);
  assign count_ext = SW'(count);
  assign pos_ext   = SW'(cmd.position);

  // decode the command against current head and count
  always_comb begin
    head_next  = head;
    count_next = count;
    ram_addr   = head;
    ram_we     = 1'b0;
    op_ok      = 1'b0;
    op_rd      = 1'b0;
    if (accept) begin
      case (cmd.opcode)
        bdq_pkg::OP_PUSH_FRONT: begin
          if (!full) begin
            head_next  = (head == '0) ? PTR_W'(DEPTH - 1) : head - 1'b1;
            ram_addr   = head_next;
            ram_we     = 1'b1;
            count_next = count + 1'b1;
            op_ok      = 1'b1;
          end
        end
        bdq_pkg::OP_PUSH_BACK: begin
          if (!full) begin
            ram_addr   = wrap_add(head_ext, count_ext);
            ram_we     = 1'b1;
            count_next = count + 1'b1;
            op_ok      = 1'b1;
          end
        end
        bdq_pkg::OP_POP_FRONT: begin
          if (!empty) begin
            ram_addr   = head;
            head_next  = wrap_add(head_ext, SW'(1));
            count_next = count - 1'b1;
            op_ok      = 1'b1;
            op_rd      = 1'b1;
          end
        end
        bdq_pkg::OP_POP_BACK: begin
          if (!empty) begin
            ram_addr   = wrap_add(head_ext, count_ext - SW'(1));
            count_next = count - 1'b1;
            op_ok      = 1'b1;
            op_rd      = 1'b1;
          end
        end
        bdq_pkg::OP_READ: begin
          if (pos_ext < count_ext) begin
            ram_addr = wrap_add(head_ext, pos_ext);
            op_ok    = 1'b1;
            op_rd    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // element store
  bdq_ram #(
    .WIDTH (bdq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd.push_data),
    .rdata (ram_rdata)
  );

  // pointer and count state
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      res_valid <= accept;
    end
  end

  // result fields, aligned with the ram read data
  assign occ_ext = SW'(count_next);
  always_ff @(posedge clk) begin
    res_ok  <= op_ok;
    res_rd  <= op_rd;
    res_occ <= occ_ext[bdq_pkg::OCC_W-1:0];
  end

  // drive the result transfer
  assign strobe           = res_valid;
  assign result.data_out  = res_rd ? ram_rdata : '0;
  assign result.ok        = res_ok;
  assign result.occupancy = res_occ;

endmodule

`default_nettype wire
